@@ rtl/dds_pkg.sv @@
// shared types, constants and the sine table function for the dds waveform generator
package dds_pkg;

   localparam int TABLE_DEPTH  = 256;
   localparam int INDEX_SHIFT  = 24;
   localparam int SAMPLE_WIDTH = 16;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int SHAPE_W      = 17;
   localparam int QUEUE_DEPTH  = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_SHAPE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_AMPLITUDE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_LEVEL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_COUNT     = 3'd4;

   localparam logic [1:0] SHAPE_SINE     = 2'd0;
   localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
   localparam logic [1:0] SHAPE_SAWTOOTH = 2'd3;

   localparam logic [14:0] HALF_AMPLITUDE_RESET = 15'd16384;
   localparam logic [7:0]  HIGH_COUNT_RESET     = 8'd128;

   typedef struct packed {
      logic [1:0]         wave_shape;
      logic [31:0]        phase_step;
      logic [14:0]        half_amplitude;
      logic signed [15:0] offset_level;
      logic [7:0]         high_count;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] table_index;
   } queue_entry_type;

   // quarter-wave folded Q30 taylor series, rounded to Q1.15
   function automatic logic signed [SHAPE_W-1:0] sine_q15(input int unsigned i);
      logic [63:0]        t32;
      logic [63:0]        frac;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        mag;
      logic [1:0]         quad;
      t32  = (64'(i) << 32) / TABLE_DEPTH;
      quad = t32[31:30];
      frac = {34'd0, t32[29:0]};
      if (quad[0]) begin
         frac = 64'd1073741824 - frac;
      end
      x    = (frac * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      mag = ($unsigned(sum) + 64'd16384) >> 15;
      if (mag > 64'd32768) begin
         mag = 64'd32768;
      end
      if (quad[1]) begin
         return -$signed(SHAPE_W'(mag));
      end
      return $signed(SHAPE_W'(mag));
   endfunction

endpackage

@@ rtl/dds_req_if.sv @@
// tick request channel: valid, ready and the restart flag
interface dds_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/dds_rsp_if.sv @@
// sample response channel: valid, ready, sample and table index
interface dds_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic [7:0]         table_index;

   modport source (output valid, output sample, output table_index, input ready);
   modport sink (input valid, input sample, input table_index, output ready);
endinterface

@@ rtl/dds_waveform_generator_core.sv @@
// Direct digital synthesizer: every accepted tick advances a 32-bit phase accumulator by
// phase_step (after clearing it when restart is set), takes the top index bits, and returns
// one sample of the selected shape (sine table, square, triangle or sawtooth), scaled by
// half_amplitude, offset by offset_level and saturated. One tick is accepted and one sample
// delivered per clock cycle in steady state. An accepted tick's index is written into a queue slot,
// then passes through the shape lookup, multiply and output registers before its sample is valid.
// The front end stalls only when the four-entry index queue is full, which happens only when the
// response side stalls. Registers must be written through the csr port only while no
// transaction is in flight; the user is bound by this and the block itself does not enforce it.
module dds_waveform_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   dds_req_if.sink                            req_if,
   dds_rsp_if.source                          rsp_if,
   input  logic                               csr_write_en,
   input  logic [dds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dds_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   dds_pkg::cfg_type         cfg_ff;
   dds_pkg::cfg_type         cfg_in;
   logic                     push;
   logic                     pop;
   logic                     q_full;
   logic                     q_empty;
   dds_pkg::queue_entry_type push_entry;
   dds_pkg::queue_entry_type pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            dds_pkg::CSR_WAVE_SHAPE:     cfg_in.wave_shape     = csr_wdata[1:0];
            dds_pkg::CSR_PHASE_STEP:     cfg_in.phase_step     = csr_wdata[31:0];
            dds_pkg::CSR_HALF_AMPLITUDE: cfg_in.half_amplitude = csr_wdata[14:0];
            dds_pkg::CSR_OFFSET_LEVEL:   cfg_in.offset_level   = $signed(csr_wdata[15:0]);
            dds_pkg::CSR_HIGH_COUNT:     cfg_in.high_count     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_shape     <= dds_pkg::SHAPE_SINE;
         cfg_ff.phase_step     <= '0;
         cfg_ff.half_amplitude <= dds_pkg::HALF_AMPLITUDE_RESET;
         cfg_ff.offset_level   <= '0;
         cfg_ff.high_count     <= dds_pkg::HIGH_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .phase_step (cfg_ff.phase_step),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   dds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   dds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp       (rsp_if)
   );

   // no write into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("index queue overflow");

   // no read from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_empty)
      else $error("index queue underflow");

   // a restart tick indexes with the step alone
   assert property (@(posedge clock) disable iff (reset)
         (push && req_if.restart) |->
         (push_entry.table_index ==
          dds_pkg::IDX_W'(cfg_ff.phase_step >> dds_pkg::INDEX_SHIFT)))
      else $error("restart did not clear the phase accumulator");

   // reset empties the output stage
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid after reset");

endmodule

@@ rtl/dds_front.sv @@
// front end: takes ticks, advances the phase accumulator and queues the table index
module dds_front (
   input  logic                     clock,
   input  logic                     reset,
   dds_req_if.sink                  req,
   input  logic [31:0]              phase_step,
   input  logic                     q_full,
   output logic                     push,
   output dds_pkg::queue_entry_type push_entry
);

   logic [31:0] phase_ff;
   logic [31:0] phase_in;
   logic [31:0] phase_sum;

   assign req.ready = !q_full;
   assign push      = req.valid && req.ready;

   // restart clears the accumulator before this tick's step
   assign phase_sum = (req.restart ? 32'd0 : phase_ff) + phase_step;
   assign phase_in  = push ? phase_sum : phase_ff;

   assign push_entry.table_index = dds_pkg::IDX_W'(phase_sum >> dds_pkg::INDEX_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/dds_queue.sv @@
// small fifo of table indexes between the front and back ends
module dds_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dds_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output dds_pkg::queue_entry_type pop_entry,
   output logic                     full,
   output logic                     empty
);

   localparam int PTR_W = $clog2(dds_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(dds_pkg::QUEUE_DEPTH + 1);

   dds_pkg::queue_entry_type mem_ff [dds_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(dds_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(dds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(dds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/dds_back.sv @@
// back end: shape lookup, amplitude multiply, offset and saturation, output register
module dds_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dds_pkg::cfg_type         cfg,
   input  logic                     q_empty,
   input  dds_pkg::queue_entry_type pop_entry,
   output logic                     pop,
   dds_rsp_if.source                rsp
);

   localparam int TRI_SHIFT = 17 - dds_pkg::IDX_W;
   localparam int SAW_SHIFT = 16 - dds_pkg::IDX_W;
   localparam logic signed [18:0] Q15_ONE   = 19'sd32768;
   localparam logic signed [18:0] Q15_THREE = 19'sd98304;
   localparam logic signed [18:0] SAT_MAX   = 19'((1 << (dds_pkg::SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [18:0] SAT_MIN   = -SAT_MAX - 19'sd1;

   logic signed [dds_pkg::SHAPE_W-1:0] sine_rom [dds_pkg::TABLE_DEPTH];

   for (genvar g = 0; g < dds_pkg::TABLE_DEPTH; g++) begin : g_rom
      assign sine_rom[g] = dds_pkg::sine_q15(g);
   end

   logic                               a_valid_ff, a_valid_in;
   logic signed [dds_pkg::SHAPE_W-1:0] a_shape_ff, a_shape_in;
   logic [dds_pkg::IDX_W-1:0]          a_idx_ff;
   logic                               b_valid_ff, b_valid_in;
   logic signed [32:0]                 b_prod_ff;
   logic [dds_pkg::IDX_W-1:0]          b_idx_ff;
   logic                               c_valid_ff, c_valid_in;
   logic signed [15:0]                 c_sample_ff, c_sample_in;
   logic [dds_pkg::IDX_W-1:0]          c_idx_ff;

   logic a_ready, b_ready, c_ready;
   logic a_load, b_load, c_load;

   logic [dds_pkg::IDX_W-1:0] idx;
   logic [7:0]                hc;
   logic signed [18:0]        ramp_tri, ramp_saw, shape_wide;
   logic signed [17:0]        scaled;
   logic signed [18:0]        level;

   assign c_ready = !c_valid_ff || rsp.ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign pop     = !q_empty && a_ready;
   assign a_load  = pop;
   assign b_load  = a_valid_ff && b_ready;
   assign c_load  = b_valid_ff && c_ready;

   assign a_valid_in = a_load || (a_valid_ff && !b_ready);
   assign b_valid_in = b_load || (b_valid_ff && !c_ready);
   assign c_valid_in = c_load || (c_valid_ff && !rsp.ready);

   // stage a: shape value in q1.15 from the table index
   assign idx      = pop_entry.table_index;
   assign ramp_tri = 19'(idx) << TRI_SHIFT;
   assign ramp_saw = 19'(idx) << SAW_SHIFT;

   always_comb begin
      hc = cfg.high_count;
      if (hc == 8'd0) begin
         hc = 8'd1;
      end
      if (int'(hc) >= dds_pkg::TABLE_DEPTH) begin
         hc = 8'(dds_pkg::TABLE_DEPTH - 1);
      end
      case (cfg.wave_shape)
         dds_pkg::SHAPE_SINE: begin
            shape_wide = 19'(sine_rom[idx]);
         end
         dds_pkg::SHAPE_SQUARE: begin
            shape_wide = (int'(idx) < int'(hc)) ? Q15_ONE : -Q15_ONE;
         end
         dds_pkg::SHAPE_TRIANGLE: begin
            if (int'(idx) < dds_pkg::TABLE_DEPTH / 2) begin
               shape_wide = ramp_tri - Q15_ONE;
            end else begin
               shape_wide = Q15_THREE - ramp_tri;
            end
         end
         default: begin
            shape_wide = ramp_saw - Q15_ONE;
         end
      endcase
      a_shape_in = dds_pkg::SHAPE_W'(shape_wide);
   end

   // stage c: floor shift, offset, saturate
   assign scaled = 18'(b_prod_ff >>> 15);
   assign level  = 19'(scaled) + 19'(cfg.offset_level);

   always_comb begin
      if (level > SAT_MAX) begin
         c_sample_in = 16'(SAT_MAX);
      end else if (level < SAT_MIN) begin
         c_sample_in = 16'(SAT_MIN);
      end else begin
         c_sample_in = 16'(level);
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_shape_ff <= a_shape_in;
         a_idx_ff   <= idx;
      end
      if (b_load) begin
         b_prod_ff <= a_shape_ff * $signed({1'b0, cfg.half_amplitude});
         b_idx_ff  <= a_idx_ff;
      end
      if (c_load) begin
         c_sample_ff <= c_sample_in;
         c_idx_ff    <= b_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   assign rsp.valid       = c_valid_ff;
   assign rsp.sample      = c_sample_ff;
   assign rsp.table_index = 8'(c_idx_ff);

endmodule
